// ----- design/bcu_pkg.sv -----
`default_nettype none

package bcu_pkg;

	// Field widths
	localparam int N_W    = 7;
	localparam int COEF_W = 64;

	// Largest accepted n or m
	localparam int MAX_N = 127;

	// Divider: dividend padded to an even width, two quotient bits per cycle
	localparam int PROD_W    = COEF_W + N_W;
	localparam int DIV_W     = PROD_W + (PROD_W % 2);
	localparam int DIV_STEPS = DIV_W / 2;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} bcu_state_t;

	// Sequencer to divider
	typedef struct packed {
		logic start;
	} div_ctrl_t;

	// Divider to sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ----- design/bcu_div.sv -----
`default_nettype none

module bcu_div import bcu_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire div_ctrl_t        ctrl,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [N_W-1:0]   divisor,
	output div_stat_t             stat,
	output logic [DIV_W-1:0]      quotient
);

	logic [DIV_W-1:0] dq_q;
	logic [N_W-1:0]   rem_q;
	logic [N_W-1:0]   dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DIV_W-1:0] dq_next;
	logic [N_W-1:0]   rem_next;

	// Two restoring steps per cycle; quotient bits shift in behind the dividend
	always_comb begin
		logic [N_W:0] part;
		logic [1:0]   qb;
		rem_next = rem_q;
		qb = '0;
		for (int s = 0; s < 2; s++) begin
			part = {rem_next, dq_q[DIV_W-1-s]};
			if (part >= {1'b0, dvs_q}) begin
				part = part - {1'b0, dvs_q};
				qb[1-s] = 1'b1;
			end
			rem_next = part[N_W-1:0];
		end
		dq_next = {dq_q[DIV_W-3:0], qb};
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= dq_next;
			rem_q <= rem_next;
		end
	end

	// Step counter and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (ctrl.start) begin
			cnt_q  <= CNT_W'(DIV_STEPS);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dq_q;

`ifndef SYNTHESIS
	// No restart while a division runs
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> !busy_q)
		else $error("divider restarted while busy");

	// Last step leads straight to done
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == CNT_W'(1) && !ctrl.start) |=> done_q)
		else $error("divider done missing");

	// Every division here is exact
	a_exact: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q == '0)
		else $error("divider remainder nonzero");
`endif

endmodule

`default_nettype wire

// ----- design/binomial_coefficient_unit.sv -----
`default_nettype none

// Sequence: invalid requests and k = 0 go straight to the finish state; other requests run k
//   rounds, k = min(m, n-m), at most 63, fewer on overflow.
// Each round is one 64x7 multiply, 36 radix-4 divide steps by i and a quotient update.
// Requests: one item at a time; the next request is taken once the result is in the output
//   register, which holds it until transferred.
// Reset: arst_n asynchronous, active low, clears control and valid flags.
module binomial_coefficient_unit import bcu_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic [N_W-1:0]    total_items,
	input  wire logic [N_W-1:0]    chosen_items,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output logic [COEF_W-1:0]      coefficient,
	output logic                   overflowed,
	output logic                   invalid_request
);

	bcu_state_t state_q;

	logic [COEF_W-1:0] r_q;
	logic [N_W-1:0]    k_q;
	logic [N_W-1:0]    base_q;
	logic [N_W-1:0]    i_q;
	logic              ovf_q;
	logic              inv_q;

	logic [COEF_W-1:0] coef_q;
	logic              ovfo_q;
	logic              invo_q;
	logic              rsp_valid_q;

	div_ctrl_t         dctrl;
	div_stat_t         dstat;
	logic [DIV_W-1:0]  quo;
	logic [DIV_W-1:0]  prod;
	logic [N_W-1:0]    factor;

	logic              req_xfer;
	logic              rsp_free;
	logic [N_W-1:0]    diff;
	logic [N_W-1:0]    kk;
	logic              bad;

	assign req_stall = (state_q != ST_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// Request decode
	assign diff = total_items - chosen_items;
	assign kk   = (chosen_items < diff) ? chosen_items : diff;
	assign bad  = (chosen_items > total_items) || (32'(total_items) > MAX_N)
		|| (32'(chosen_items) > MAX_N);

	// Shared multiply: running value times next numerator term
	assign factor      = base_q + i_q;
	assign prod        = DIV_W'(r_q) * DIV_W'(factor);
	assign dctrl.start = (state_q == ST_MUL);

	bcu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (dctrl),
		.dividend (prod),
		.divisor  (i_q),
		.stat     (dstat),
		.quotient (quo)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						state_q <= (bad || kk == '0) ? ST_FIN : ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (dstat.done) begin
						if (quo[DIV_W-1:COEF_W] != '0 || i_q == k_q) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_FIN: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			r_q    <= bad ? '0 : COEF_W'(1);
			inv_q  <= bad;
			ovf_q  <= 1'b0;
			k_q    <= kk;
			base_q <= total_items - kk;
			i_q    <= N_W'(1);
		end else if (state_q == ST_DIV && dstat.done) begin
			if (quo[DIV_W-1:COEF_W] != '0) begin
				ovf_q <= 1'b1;
			end else begin
				r_q <= quo[COEF_W-1:0];
				if (i_q != k_q) begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && rsp_free) begin
			coef_q <= ovf_q ? '1 : r_q;
			ovfo_q <= ovf_q;
			invo_q <= inv_q;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign coefficient     = coef_q;
	assign overflowed      = ovfo_q;
	assign invalid_request = invo_q;

`ifndef SYNTHESIS
	// One request at a time: stall follows a request transfer
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> req_stall)
		else $error("request taken while still working");

	// Flags are exclusive
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(overflowed && invalid_request))
		else $error("overflow and invalid both set");

	// Invalid gives zero
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && invalid_request) |-> coefficient == '0)
		else $error("invalid result not zero");

	// Overflow saturates
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && overflowed) |-> (&coefficient))
		else $error("overflow result not saturated");
`endif

endmodule

`default_nettype wire
